>>> hw/rtl/isa_pkg.sv
// ----------------------------------------------------------------------------
// isa_pkg
// Shared types, codes and defaults of the image slot allocator.
// ----------------------------------------------------------------------------
package isa_pkg;

	localparam int SLOTS_DEF           = 16;
	localparam int BLOCKS_PER_SLOT_DEF = 8;
	localparam int FIRST_BLOCK_DEF     = 8;

	// field widths
	localparam int ACTION_W = 2;
	localparam int KIND_W   = 8;
	localparam int RANK_W   = 4;
	localparam int STATUS_W = 2;
	localparam int BLOCK_W  = 8;
	localparam int NAME_W   = 32;
	localparam int COUNT_W  = 5;

	// stream payload widths, rounded up to whole bytes
	localparam int IN_W  = 16;
	localparam int OUT_W = 56;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_SAVE   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_RANK = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNUSED  = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BLOCK_W-1:0]  block_number;
		logic [NAME_W-1:0]   image_name;
		logic [KIND_W-1:0]   kind_out;
		logic [COUNT_W-1:0]  image_count;
	} isa_result_t;

endpackage

>>> hw/rtl/image_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// image_slot_allocator_core
// Free-slot FIFO, newest-first rank list and per-slot name/kind store, each
// held in a one-port-read RAM and updated by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// channel  direction  payload (lowest bit up)
// s_*      in         action[1:0] image_kind[9:2] rank[13:10]
// m_*      out        status[1:0] block_number[9:2] image_name[41:10]
//                     kind_out[49:42] image_count[54:50]
//
// Lookup: S_DL_A, S_DL_B, result register. Delete: also S_DSH, which moves each
// older entry up a rank. Save: S_SV_A, S_SV_B, S_SH moving each stored entry
// down a rank, S_SVF writing the new one. Rejected items go straight to S_OUT.
// The rank list shifts one entry per cycle through its single read port.
// Reset needs no clearing pass: the free FIFO has one valid bit per entry.
// A new item is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module image_slot_allocator_core #(
	parameter int SLOTS           = isa_pkg::SLOTS_DEF,
	parameter int BLOCKS_PER_SLOT = isa_pkg::BLOCKS_PER_SLOT_DEF,
	parameter int FIRST_BLOCK     = isa_pkg::FIRST_BLOCK_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [isa_pkg::IN_W-1:0] s_tdata,   // action, image_kind, rank
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [isa_pkg::OUT_W-1:0] m_tdata   // status, block_number, image_name,
	                                            // kind_out, image_count
);
	import isa_pkg::*;

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int SD = NAME_W + KIND_W;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SV_A = 9'b000000010,
		S_SV_B = 9'b000000100,
		S_SH   = 9'b000001000,
		S_SVF  = 9'b000010000,
		S_DL_A = 9'b000100000,
		S_DL_B = 9'b001000000,
		S_DSH  = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [ACTION_W-1:0] in_action;
	logic [KIND_W-1:0]   in_kind;
	logic [RANK_W-1:0]   in_rank;

	logic [ACTION_W-1:0] act_q;
	logic [KIND_W-1:0]   kind_q;
	logic [NAME_W-1:0]   name_q;
	logic [SW-1:0]       slot_q;
	logic [SW-1:0]       p_q;
	logic [SW-1:0]       free_head_q;
	logic [SW-1:0]       free_tail_q;
	logic [CW-1:0]       free_count_q;
	logic [CW-1:0]       stored_q;
	logic [SLOTS-1:0]    free_vld_q;
	isa_result_t         res_q;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	// RAM ports
	logic          free_we;
	logic [SW-1:0] free_rdata;
	logic          rank_we;
	logic [SW-1:0] rank_waddr, rank_wdata, rank_raddr, rank_rdata;
	logic          store_we;
	logic [SD-1:0] store_wdata, store_rdata;

	logic          accept;
	logic [15:0]   blk_full;
	logic [SW-1:0] head_next, tail_next;

	assign in_action = s_tdata[1:0];
	assign in_kind   = s_tdata[9:2];
	assign in_rank   = s_tdata[13:10];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign blk_full  = 16'(FIRST_BLOCK) + 16'(slot_q) * 16'(BLOCKS_PER_SLOT);
	assign head_next = (free_head_q == SW'(SLOTS - 1)) ? '0 : free_head_q + SW'(1);
	assign tail_next = (free_tail_q == SW'(SLOTS - 1)) ? '0 : free_tail_q + SW'(1);

	isa_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_free_ram (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_tail_q),
		.wdata (slot_q),
		.raddr (free_head_q),
		.rdata (free_rdata)
	);

	isa_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (rank_waddr),
		.wdata (rank_wdata),
		.raddr (rank_raddr),
		.rdata (rank_rdata)
	);

	isa_ram #(.WIDTH(SD), .DEPTH(SLOTS)) u_store_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (slot_q),
		.wdata (store_wdata),
		.raddr (rank_rdata),
		.rdata (store_rdata)
	);

	always_comb begin
		free_we     = 1'b0;
		rank_we     = 1'b0;
		rank_waddr  = p_q;
		rank_wdata  = rank_rdata;
		store_we    = 1'b0;
		store_wdata = '0;
		unique case (state_q)
			S_IDLE: rank_raddr = (in_action == ACT_SAVE) ? '0 : SW'(in_rank);
			S_SV_B: rank_raddr = p_q - SW'(1);
			S_SH: begin
				rank_raddr = p_q - SW'(2);
				rank_we    = 1'b1;
			end
			S_SVF: begin
				rank_raddr  = '0;
				rank_we     = 1'b1;
				rank_waddr  = '0;
				rank_wdata  = slot_q;
				store_we    = 1'b1;
				store_wdata = {name_q, kind_q};
			end
			S_DL_B: begin
				rank_raddr = p_q + SW'(1);
				if (act_q == ACT_DELETE) begin
					free_we  = 1'b1;
					store_we = 1'b1;
				end
			end
			S_DSH: begin
				rank_raddr = p_q + SW'(2);
				rank_we    = 1'b1;
			end
			default: rank_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			free_head_q  <= '0;
			free_tail_q  <= '0;
			free_count_q <= CW'(SLOTS);
			stored_q     <= '0;
			free_vld_q   <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_action == ACT_SAVE && free_count_q != '0 &&
						    stored_q < CW'(SLOTS)) begin
							state_q <= S_SV_A;
						end else if (in_action != ACT_SAVE && in_action != ACT_NONE &&
						             8'(in_rank) < 8'(stored_q)) begin
							state_q <= S_DL_A;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_SV_A: begin
					free_head_q  <= head_next;
					free_count_q <= free_count_q - CW'(1);
					state_q      <= S_SV_B;
				end
				S_SV_B: state_q <= (stored_q == '0) ? S_SVF : S_SH;
				S_SH: begin
					if (p_q == SW'(1)) begin
						state_q <= S_SVF;
					end
				end
				S_SVF: begin
					stored_q <= stored_q + CW'(1);
					state_q  <= S_OUT;
				end
				S_DL_A: state_q <= S_DL_B;
				S_DL_B: begin
					if (act_q == ACT_DELETE) begin
						free_vld_q[free_tail_q] <= 1'b1;
						free_tail_q  <= tail_next;
						free_count_q <= free_count_q + CW'(1);
						if ((CW+1)'(p_q) + (CW+1)'(1) < (CW+1)'(stored_q)) begin
							state_q <= S_DSH;
						end else begin
							stored_q <= stored_q - CW'(1);
							state_q  <= S_OUT;
						end
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DSH: begin
					if ((CW+1)'(p_q) + (CW+1)'(2) >= (CW+1)'(stored_q)) begin
						stored_q <= stored_q - CW'(1);
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					// hold the result until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				act_q  <= in_action;
				kind_q <= in_kind;
				p_q    <= SW'(in_rank);
				res_q  <= '{status: (in_action == ACT_SAVE) ? ST_NO_FREE : ST_NO_RANK,
				           block_number: '0, image_name: '0, kind_out: '0,
				           image_count: COUNT_W'(stored_q)};
			end
			S_SV_A: begin
				slot_q <= free_vld_q[free_head_q] ? free_rdata : free_head_q;
				p_q    <= SW'(stored_q);
			end
			S_SV_B: name_q <= (stored_q == '0) ? NAME_W'(1)
			                                  : store_rdata[SD-1:KIND_W] + NAME_W'(1);
			S_SH: p_q <= p_q - SW'(1);
			S_SVF: res_q <= '{status: ST_OK, block_number: blk_full[BLOCK_W-1:0],
			                  image_name: name_q, kind_out: kind_q,
			                  image_count: COUNT_W'(stored_q + CW'(1))};
			S_DL_A: slot_q <= rank_rdata;
			S_DL_B: res_q <= '{status: ST_OK, block_number: blk_full[BLOCK_W-1:0],
			                   image_name: store_rdata[SD-1:KIND_W],
			                   kind_out: store_rdata[KIND_W-1:0],
			                   image_count: (act_q == ACT_DELETE)
			                                ? COUNT_W'(stored_q - CW'(1))
			                                : COUNT_W'(stored_q)};
			S_DSH: p_q <= p_q + SW'(1);
			S_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {1'b0, res_q.image_count, res_q.kind_out, res_q.image_name,
					              res_q.block_number, res_q.status};
				end
			end
			default: ;
		endcase
	end

endmodule

>>> hw/rtl/isa_ram.sv
// ----------------------------------------------------------------------------
// isa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module isa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/isa_checker.sv
// ----------------------------------------------------------------------------
// isa_checker
// Port-level checks of the image slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module isa_checker #(
	parameter int SLOTS = isa_pkg::SLOTS_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [isa_pkg::IN_W-1:0]  s_tdata,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [isa_pkg::OUT_W-1:0] m_tdata
);
	import isa_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one item at a time: busy right after a transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in progress");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != ST_UNUSED)
		else $error("undefined status code");

	// a refused item reports zero block, name and kind
	a_refuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[49:2] == '0)
		else $error("refused item carries data");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && SLOTS < 32 |-> 32'(m_tdata[54:50]) <= 32'(SLOTS))
		else $error("image count exceeds slot count");

endmodule

bind image_slot_allocator_core isa_checker #(.SLOTS(SLOTS)) u_isa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the image slot allocator. It sends save, delete,
// lookup and unused actions over the input stream and predicts each result
// from its own copy of the free FIFO, rank list and slot stores. Both stream
// sides idle at random, and the scoreboard compares each result field by field.
// ----------------------------------------------------------------------------
module tb;
	import isa_pkg::*;

	localparam int NSLOT      = SLOTS_DEF;
	localparam int STALL_MAX  = 2000;
	localparam int SETTLE     = 40;
	localparam int RAND_ITEMS = 750;
	localparam int PRINT_MAX  = 100;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	bit steady = 1'b0;
	int stall_cycles = 0;

	// Tracks slot ownership the way the block should and queues the results it owes.
	class slot_scoreboard;
		logic [RANK_W-1:0] free_ring[NSLOT];
		logic [RANK_W-1:0] rank_order[NSLOT];
		logic [NAME_W-1:0] names[NSLOT];
		logic [KIND_W-1:0] kinds[NSLOT];
		int free_head;
		int free_tail;
		int free_count;
		int stored;
		int errors;
		isa_result_t owed[$];

		function new();
			for (int i = 0; i < NSLOT; i++) begin
				free_ring[i] = RANK_W'(i);
				rank_order[i] = '0;
				names[i] = '0;
				kinds[i] = '0;
			end
			free_head = 0;
			free_tail = 0;
			free_count = NSLOT;
			stored = 0;
			errors = 0;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_MAX)
				$display("mismatch %0d: %s", errors, msg);
		endtask

		function void note_request(logic [ACTION_W-1:0] act, logic [KIND_W-1:0] kind,
				logic [RANK_W-1:0] rank);
			isa_result_t r;
			int slot;
			int blk;
			r = '0;
			if (act == ACT_SAVE) begin
				if (free_count == 0) begin
					r.status = ST_NO_FREE;
				end else begin
					slot = free_ring[free_head];
					free_head = (free_head + 1) % NSLOT;
					free_count--;
					if (stored > 0)
						r.image_name = names[rank_order[0]] + 1'b1;
					else
						r.image_name = 1;
					for (int i = stored; i > 0; i--)
						rank_order[i] = rank_order[i - 1];
					rank_order[0] = RANK_W'(slot);
					stored++;
					names[slot] = r.image_name;
					kinds[slot] = kind;
					blk = FIRST_BLOCK_DEF + slot * BLOCKS_PER_SLOT_DEF;
					r.status = ST_OK;
					r.block_number = blk[BLOCK_W-1:0];
					r.kind_out = kind;
				end
			end else if (act == ACT_NONE || rank >= stored) begin
				r.status = ST_NO_RANK;
			end else begin
				slot = rank_order[rank];
				blk = FIRST_BLOCK_DEF + slot * BLOCKS_PER_SLOT_DEF;
				r.status = ST_OK;
				r.block_number = blk[BLOCK_W-1:0];
				r.image_name = names[slot];
				r.kind_out = kinds[slot];
				if (act == ACT_DELETE) begin
					names[slot] = '0;
					kinds[slot] = '0;
					free_ring[free_tail] = RANK_W'(slot);
					free_tail = (free_tail + 1) % NSLOT;
					free_count++;
					// close the gap left in the rank list
					for (int i = rank; i + 1 < stored; i++)
						rank_order[i] = rank_order[i + 1];
					stored--;
				end
			end
			r.image_count = COUNT_W'(stored);
			owed.push_back(r);
		endfunction

		task check_result(logic [OUT_W-1:0] d);
			isa_result_t got;
			isa_result_t want;
			got.status       = d[1:0];
			got.block_number = d[9:2];
			got.image_name   = d[41:10];
			got.kind_out     = d[49:42];
			got.image_count  = d[54:50];
			if (owed.size() == 0) begin
				report("result arrived with nothing outstanding");
			end else begin
				want = owed.pop_front();
				if (got.status != want.status)
					report($sformatf("status got %0d want %0d", got.status, want.status));
				if (got.block_number != want.block_number)
					report($sformatf("block_number got %0d want %0d",
						got.block_number, want.block_number));
				if (got.image_name != want.image_name)
					report($sformatf("image_name got %0d want %0d",
						got.image_name, want.image_name));
				if (got.kind_out != want.kind_out)
					report($sformatf("kind_out got %0d want %0d",
						got.kind_out, want.kind_out));
				if (got.image_count != want.image_count)
					report($sformatf("image_count got %0d want %0d",
						got.image_count, want.image_count));
			end
		endtask
	endclass

	slot_scoreboard sb = new();

	image_slot_allocator_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 36);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// End the run once nothing has moved on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_MAX) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic send(logic [ACTION_W-1:0] act, logic [KIND_W-1:0] kind,
			logic [RANK_W-1:0] rank);
		while (!steady && $urandom_range(0, 99) < 36) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, rank, kind, act};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(act, kind, rank);
	endtask

	// Hold the input side until every owed result has been taken.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [ACTION_W-1:0] act;
		logic [RANK_W-1:0]   rank;
		int                  pick;
		bit                  grow;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty allocator: nothing to delete or look up
		send(ACT_LOOKUP, 8'h00, 4'd0);
		send(ACT_DELETE, 8'h5a, 4'd15);
		send(ACT_NONE, 8'hff, 4'd15);
		// fill every slot, kind extremes first
		send(ACT_SAVE, 8'h00, 4'd0);
		send(ACT_SAVE, 8'hff, 4'd15);
		for (int i = 2; i < NSLOT; i++)
			send(ACT_SAVE, KIND_W'($urandom_range(0, 255)), RANK_W'($urandom_range(0, 15)));
		// full: save must be refused
		send(ACT_SAVE, 8'h3c, 4'd0);
		send(ACT_LOOKUP, 8'h00, 4'd15);
		send(ACT_LOOKUP, 8'hff, 4'd0);
		send(ACT_NONE, 8'h00, 4'd0);
		// oldest, newest, then a middle rank
		send(ACT_DELETE, 8'h00, 4'd15);
		send(ACT_DELETE, 8'h00, 4'd0);
		send(ACT_DELETE, 8'h00, 4'd7);
		send(ACT_SAVE, 8'ha5, 4'd0);
		drain();

		grow = 1'b1;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 60 == 0)
				grow = ~grow;
			steady = (n >= 300 && n < 420);
			if (n % 200 == 199)
				drain();
			pick = $urandom_range(0, 99);
			if (pick < 3)
				act = ACT_NONE;
			else if (pick < (grow ? 65 : 28))
				act = ACT_SAVE;
			else if (pick < (grow ? 82 : 78))
				act = ACT_DELETE;
			else
				act = ACT_LOOKUP;
			if (sb.stored > 0 && $urandom_range(0, 9) < 8)
				rank = RANK_W'($urandom_range(0, sb.stored - 1));
			else
				rank = RANK_W'($urandom_range(0, 15));
			send(act, KIND_W'($urandom_range(0, 255)), rank);
		end
		steady = 1'b0;
		drain();
		repeat (SETTLE) @(posedge clk);

		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
